/* hw/rtl/modbus_rtu_frame_buffer_defines.svh */
// Assertion macros used by the frame buffer top level.
`ifndef MODBUS_RTU_FRAME_BUFFER_DEFINES_SVH
`define MODBUS_RTU_FRAME_BUFFER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MRFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame buffer check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MRFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame buffer check failed");

`endif

/* hw/rtl/mrfb_pkg.sv */
package mrfb_pkg;

    localparam int STORE_DEPTH_DEF = 256;
    localparam int MAX_FRAME_DEF   = 254;
    localparam logic [7:0] TIMEOUT_RESET = 8'd125;

    typedef enum logic [2:0] {
        FUNC_RX_BYTE    = 3'd0,
        FUNC_TICK       = 3'd1,
        FUNC_TX_READY   = 3'd2,
        FUNC_BUF_WRITE  = 3'd3,
        FUNC_BUF_READ   = 3'd4,
        FUNC_EVENT_POLL = 3'd5,
        FUNC_START_TX   = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        MODE_RX   = 2'd0,
        MODE_HALT = 2'd1,
        MODE_TX   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_TX   = 2'd1,
        EV_RX   = 2'd2
    } event_t;

    localparam logic EVENT_KIND_TX = 1'b1;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data;
        logic       parity_error;
        logic [7:0] index;
        logic       event_kind;
    } mrfb_in_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] read_byte;
        logic       event_hit;
        logic       driver_enable;
        logic       frame_done;
    } mrfb_out_t;

    // One access to the frame store; write and read never occur together.
    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [7:0] raddr;
    } mrfb_mem_req_t;

    // Tells the result merge where the store read data belongs.
    typedef struct packed {
        logic use_mem;
        logic mem_to_tx;
    } mrfb_sel_t;

endpackage

/* hw/rtl/mrfb_store.sv */
module mrfb_store
    import mrfb_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
)
(
    input  logic          clk,
    input  mrfb_mem_req_t req,
    output logic [7:0]    rdata
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/mrfb_ctrl.sv */
module mrfb_ctrl
    import mrfb_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_FRAME   = MAX_FRAME_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data,
    input  logic          item_valid,
    output logic          item_ready,
    input  mrfb_in_t      item,
    input  logic          stage_ready,
    output logic          stage_valid,
    output mrfb_out_t     stage_res,
    output mrfb_sel_t     stage_sel,
    output mrfb_mem_req_t mem_req
);

    localparam logic [8:0] DEPTH9  = 9'(STORE_DEPTH);
    localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME);

    logic       item_accept;

    logic [7:0] timeout_reg;
    logic [7:0] len_reg, len_next;
    logic       in_frame_reg, in_frame_next;
    logic [7:0] silence_reg, silence_next;
    logic       armed_reg, armed_next;
    logic [7:0] sent_reg, sent_next;
    event_t     pending_reg, pending_next;
    mode_t      mode_reg, mode_next;

    logic       a_valid_reg, a_valid_next;
    mrfb_out_t  a_res_reg, res_next;
    mrfb_sel_t  a_sel_reg, sel_next;

    logic [7:0] rx_base;
    logic [7:0] rx_addr;
    logic [7:0] rx_len;
    logic [7:0] silence_inc;
    logic [7:0] tx_addr;

    function automatic logic in_store(input logic [7:0] addr);
        in_store = (addr != 8'd0) && ({1'b0, addr} < DEPTH9);
    endfunction

    assign item_ready  = !a_valid_reg || stage_ready;
    assign item_accept = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= TIMEOUT_RESET;
            len_reg      <= 8'd0;
            in_frame_reg <= 1'b0;
            silence_reg  <= 8'd0;
            armed_reg    <= 1'b0;
            sent_reg     <= 8'd0;
            pending_reg  <= EV_NONE;
            mode_reg     <= MODE_RX;
            a_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            len_reg      <= len_next;
            in_frame_reg <= in_frame_next;
            silence_reg  <= silence_next;
            armed_reg    <= armed_next;
            sent_reg     <= sent_next;
            pending_reg  <= pending_next;
            mode_reg     <= mode_next;
            a_valid_reg  <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            a_res_reg <= res_next;
            a_sel_reg <= sel_next;
        end
    end

    always_comb
    begin
        len_next      = len_reg;
        in_frame_next = in_frame_reg;
        silence_next  = silence_reg;
        armed_next    = armed_reg;
        sent_next     = sent_reg;
        pending_next  = pending_reg;
        mode_next     = mode_reg;
        res_next      = '0;
        sel_next      = '0;
        mem_req       = '0;
        rx_base       = in_frame_reg ? len_reg : 8'd0;
        rx_addr       = rx_base + 8'd1;
        rx_len        = 8'd0;
        silence_inc   = (silence_reg != 8'hFF) ? silence_reg + 8'd1 : silence_reg;
        tx_addr       = sent_reg + 8'd1;

        if (item_accept)
        begin
            case (func_t'(item.func))
                FUNC_RX_BYTE:
                begin
                    if (mode_reg == MODE_RX)
                    begin
                        armed_next   = 1'b0;
                        silence_next = 8'd0;
                        if (!item.parity_error)
                        begin
                            in_frame_next = 1'b1;
                            // A length forced to its top value by software makes the
                            // append land on entry 0, the length itself.
                            if (rx_addr == 8'd0)
                            begin
                                rx_len = item.data + 8'd1;
                            end
                            else
                            begin
                                rx_len = rx_addr;
                                if (in_store(rx_addr))
                                begin
                                    mem_req.we    = 1'b1;
                                    mem_req.waddr = rx_addr;
                                    mem_req.wdata = item.data;
                                end
                            end
                            if (rx_len > MAX_LEN)
                            begin
                                len_next      = 8'd0;
                                in_frame_next = 1'b0;
                            end
                            else
                            begin
                                len_next   = rx_len;
                                armed_next = 1'b1;
                            end
                        end
                    end
                end
                FUNC_TICK:
                begin
                    if (armed_reg)
                    begin
                        if (silence_inc >= timeout_reg)
                        begin
                            res_next.frame_done = 1'b1;
                            pending_next        = EV_RX;
                            in_frame_next       = 1'b0;
                            armed_next          = 1'b0;
                            silence_next        = 8'd0;
                            if (mode_reg == MODE_RX)
                            begin
                                mode_next = MODE_HALT;
                            end
                        end
                        else
                        begin
                            silence_next = silence_inc;
                        end
                    end
                end
                FUNC_TX_READY:
                begin
                    if (mode_reg == MODE_TX)
                    begin
                        if (sent_reg == len_reg)
                        begin
                            pending_next = EV_TX;
                            mode_next    = MODE_RX;
                            sent_next    = 8'd0;
                        end
                        else
                        begin
                            res_next.tx_valid = 1'b1;
                            sent_next         = tx_addr;
                            if (tx_addr == 8'd0)
                            begin
                                res_next.tx_byte = len_reg;
                            end
                            else if (in_store(tx_addr))
                            begin
                                mem_req.re         = 1'b1;
                                mem_req.raddr      = tx_addr;
                                sel_next.use_mem   = 1'b1;
                                sel_next.mem_to_tx = 1'b1;
                            end
                        end
                    end
                end
                FUNC_BUF_WRITE:
                begin
                    if (item.index == 8'd0)
                    begin
                        len_next = item.data;
                    end
                    else if (in_store(item.index))
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = item.index;
                        mem_req.wdata = item.data;
                    end
                end
                FUNC_BUF_READ:
                begin
                    if (item.index == 8'd0)
                    begin
                        res_next.read_byte = len_reg;
                    end
                    else if (in_store(item.index))
                    begin
                        mem_req.re       = 1'b1;
                        mem_req.raddr    = item.index;
                        sel_next.use_mem = 1'b1;
                    end
                end
                FUNC_EVENT_POLL:
                begin
                    if (((item.event_kind == EVENT_KIND_TX) && (pending_reg == EV_TX)) ||
                        ((item.event_kind != EVENT_KIND_TX) && (pending_reg == EV_RX)))
                    begin
                        pending_next       = EV_NONE;
                        res_next.event_hit = 1'b1;
                    end
                end
                FUNC_START_TX:
                begin
                    if (mode_reg != MODE_TX)
                    begin
                        mode_next    = MODE_TX;
                        armed_next   = 1'b0;
                        silence_next = 8'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res_next.driver_enable = (mode_next == MODE_TX);

        if (item_accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (stage_ready)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end
    end

    assign stage_valid = a_valid_reg;
    assign stage_res   = a_res_reg;
    assign stage_sel   = a_sel_reg;

endmodule

/* hw/rtl/mrfb_skid.sv */
module mrfb_skid
    import mrfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  mrfb_out_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output mrfb_out_t pop_data
);

    mrfb_out_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/modbus_rtu_frame_buffer.sv */
// Half-duplex Modbus RTU frame buffer. Every transfer on the item channel is
// one operation: a received byte, a timer tick, a transmitter-ready request, a
// buffer write or read, an event poll or a start of transmit. Every item gives
// exactly one transfer on the result channel, in order. Received bytes are
// appended to the frame store (entry 0 is the frame length); when the
// configured number of ticks passes with no received byte, the result of that
// tick reports frame_done and reception halts until a transmit has run. The
// block takes one item per clock cycle; a result passes through the result
// stage register, lined up with the registered read port of the frame store,
// and then a two-entry output queue, so a stalled result channel does not stop
// items until the queue is full. The store contents are not cleared by reset:
// a read of an entry that was never written returns an arbitrary byte. The
// silence timeout register can be written at any time the block is idle.
`include "modbus_rtu_frame_buffer_defines.svh"

module modbus_rtu_frame_buffer
    import mrfb_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_FRAME   = MAX_FRAME_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       item_valid,
    output logic       item_ready,
    input  mrfb_in_t   item,
    output logic       result_valid,
    input  logic       result_ready,
    output mrfb_out_t  result
);

    logic          stage_valid;
    logic          stage_ready;
    mrfb_out_t     stage_res;
    mrfb_sel_t     stage_sel;
    mrfb_mem_req_t mem_req;
    logic [7:0]    mem_rdata;
    mrfb_out_t     merged_res;

    // Operation decode, control state and the result stage register.
    mrfb_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_FRAME   (MAX_FRAME)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .stage_ready (stage_ready),
        .stage_valid (stage_valid),
        .stage_res   (stage_res),
        .stage_sel   (stage_sel),
        .mem_req     (mem_req)
    );

    // Frame store: at most one write or one read per item; the read data register
    // lines up with the result stage register.
    mrfb_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // The store read data goes either to the transmit byte or to the read
    // byte, depending on which operation issued the read.
    always_comb
    begin
        merged_res = stage_res;
        if (stage_sel.use_mem)
        begin
            if (stage_sel.mem_to_tx)
            begin
                merged_res.tx_byte = mem_rdata;
            end
            else
            begin
                merged_res.read_byte = mem_rdata;
            end
        end
    end

    // Output queue decouples the result channel from the result stage.
    mrfb_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (stage_valid),
        .push_ready (stage_ready),
        .push_data  (merged_res),
        .pop_valid  (result_valid),
        .pop_ready  (result_ready),
        .pop_data   (result)
    );

    // A byte is only handed out while the line driver is turned to transmit.
    `MRFB_ASSERT_IMPL(a_tx_only_in_tx_mode, clk, rst_n, result_valid && result.tx_valid, result.driver_enable)

    // The silence timer is stopped by a transmit start, so a frame end never
    // shows up with the driver enabled.
    `MRFB_ASSERT_IMPL(a_done_not_in_tx, clk, rst_n, stage_valid && stage_res.frame_done, !stage_res.driver_enable)

    // The store is never written and read by the same item.
    `MRFB_ASSERT_IMPL(a_store_single_access, clk, rst_n, mem_req.we, !mem_req.re)

    // A result that cannot move on stays in the result stage unchanged.
    `MRFB_ASSERT_NEXT(a_stage_holds, clk, rst_n, stage_valid && !stage_ready, stage_valid && $stable(stage_res))

endmodule
